// File: rtl/olr_pkg.sv
// Shared types and constants for the overwriting log ring.
`default_nettype none

package olr_pkg;

  localparam int unsigned RingDepthDef  = 4096;
  localparam int unsigned MaxRequestDef = 64;

  // Fixed port field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned CursorW = 12;
  localparam int unsigned CountW  = 6;
  localparam int unsigned FillW   = 12;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic append;      // write ch into the ring this cycle if ch is nonzero
    logic accept_req;  // latch a read, drain or status request
    logic load_run;    // size the run and load its counters
    logic issue;       // read one entry and send one result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_last;    // the entry issued this cycle ends the run
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/olr_ctrl.sv
// Request sequencer for the overwriting log ring.
`default_nettype none

module olr_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [olr_pkg::OpW-1:0]      op_i,
  input  wire olr_pkg::stat_t               stat_i,
  output olr_pkg::cmd_t                     cmd_o,
  output logic                              busy_o
);

  olr_pkg::state_e state_q, state_d;
  logic            accept;
  logic            is_append;

  assign is_append = (olr_pkg::op_e'(op_i) == olr_pkg::OP_APPEND);
  assign accept    = start_i && (state_q == olr_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      olr_pkg::ST_IDLE: begin
        if (accept && !is_append) begin
          state_d = olr_pkg::ST_SETUP;
        end
      end
      olr_pkg::ST_SETUP: begin
        state_d = olr_pkg::ST_RUN;
      end
      olr_pkg::ST_RUN: begin
        if (stat_i.run_last) begin
          state_d = olr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = olr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    busy_o           = 1'b1;
    case (state_q)
      olr_pkg::ST_IDLE: begin
        busy_o           = 1'b0;
        cmd_o.append     = accept && is_append;
        cmd_o.accept_req = accept && !is_append;
      end
      olr_pkg::ST_SETUP: begin
        cmd_o.load_run = 1'b1;
      end
      olr_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/olr_datapath.sv
// Ring store, pointers, run counters and result register of the log ring.
`default_nettype none

module olr_datapath #(
  parameter int unsigned RING_DEPTH  = olr_pkg::RingDepthDef,
  parameter int unsigned MAX_REQUEST = olr_pkg::MaxRequestDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire olr_pkg::cmd_t                   cmd_i,
  output olr_pkg::stat_t                       stat_o,
  input  wire logic [olr_pkg::OpW-1:0]         op_i,
  input  wire logic [olr_pkg::ByteW-1:0]       ch_i,
  input  wire logic [olr_pkg::LenW-1:0]        max_len_i,
  input  wire logic [olr_pkg::CursorW-1:0]     cursor_i,
  output logic                                 strobe_o,
  output logic [olr_pkg::ByteW-1:0]            byte_out_o,
  output logic                                 byte_valid_o,
  output logic                                 last_o,
  output logic [olr_pkg::CountW-1:0]           count_o,
  output logic [olr_pkg::CursorW-1:0]          next_cursor_o,
  output logic [olr_pkg::FillW-1:0]            fill_level_o,
  output logic                                 overflowed_o
);

  // RING_DEPTH must be a power of two (the block does not check it), so ring arithmetic wraps in AW bits
  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (AW > olr_pkg::CursorW) ? AW : olr_pkg::CursorW;
  localparam int unsigned XW = ((AW > olr_pkg::LenW) ? AW : olr_pkg::LenW) + 1;
  localparam logic [AW-1:0] LastIdx  = AW'(RING_DEPTH - 1);
  localparam logic [olr_pkg::LenW-1:0] MaxLen = olr_pkg::LenW'(MAX_REQUEST);
  localparam logic [CW-1:0] FillSat = CW'({olr_pkg::FillW{1'b1}});

  logic [olr_pkg::ByteW-1:0] mem [RING_DEPTH];
  logic [olr_pkg::ByteW-1:0] mem_rd_q;

  logic [AW-1:0] head_q, tail_q;
  logic          evicted_q, wrapped_q;

  olr_pkg::op_e                 req_op_q;
  logic [olr_pkg::LenW-1:0]     req_ml_q;
  logic [olr_pkg::CursorW-1:0]  req_cur_q;

  logic [AW-1:0]                run_addr_q;
  logic [olr_pkg::CountW-1:0]   run_left_q;
  logic [olr_pkg::CountW-1:0]   run_cnt_q;
  logic                         run_real_q;
  logic [olr_pkg::CursorW-1:0]  run_nc_q;

  logic                         strobe_q, out_bv_q, out_last_q, out_wr_q, out_ovf_q;
  logic [olr_pkg::CountW-1:0]   out_cnt_q;
  logic [olr_pkg::CursorW-1:0]  out_nc_q;
  logic [olr_pkg::FillW-1:0]    out_fill_q;

  // Append path
  logic [AW-1:0] head_nxt;
  assign head_nxt = head_q + AW'(1);

  // Run sizing
  logic [olr_pkg::LenW-1:0]    ml_c, room;
  logic [AW-1:0]               fill_a, cur_mod, dr_avail, dr_end;
  logic [XW-1:0]               fill_x, room_x, dr_avail_x, dr_n_x;
  logic [CW-1:0]               cur_ext, fill_ext, dr_end_ext, head_ext;
  logic                        rd_big, dr_refuse;
  logic [AW-1:0]               set_addr;
  logic [olr_pkg::CountW-1:0]  set_n;
  logic [olr_pkg::CursorW-1:0] set_nc;
  logic [olr_pkg::FillW-1:0]   fill12;

  assign ml_c     = (req_ml_q > MaxLen) ? MaxLen : req_ml_q;
  assign room     = (ml_c == '0) ? '0 : ml_c - olr_pkg::LenW'(1);
  assign fill_a   = head_q - tail_q;
  assign fill_x   = XW'(fill_a);
  assign room_x   = XW'(room);
  assign rd_big   = fill_x > room_x;

  assign cur_ext    = CW'(req_cur_q);
  assign cur_mod    = cur_ext[AW-1:0];
  assign dr_avail   = head_q - cur_mod;
  assign dr_avail_x = XW'(dr_avail);
  assign dr_refuse  = (ml_c < olr_pkg::LenW'(2)) || (cur_mod == head_q);
  assign dr_n_x     = (dr_avail_x > room_x) ? room_x : dr_avail_x;
  assign dr_end     = cur_mod + dr_n_x[AW-1:0];
  assign dr_end_ext = CW'(dr_end);
  assign head_ext   = CW'(head_q);

  assign fill_ext = CW'(fill_a);
  assign fill12   = (fill_ext > FillSat) ? olr_pkg::FillW'(FillSat) : fill_ext[olr_pkg::FillW-1:0];

  always_comb begin
    set_addr = tail_q;
    set_n    = '0;
    set_nc   = '0;
    case (req_op_q)
      olr_pkg::OP_READ: begin
        if (rd_big) begin
          set_addr = head_q - room_x[AW-1:0];
          set_n    = room_x[olr_pkg::CountW-1:0];
        end else begin
          set_n    = fill_x[olr_pkg::CountW-1:0];
        end
      end
      olr_pkg::OP_DRAIN: begin
        if (dr_refuse) begin
          set_nc = req_cur_q;
        end else begin
          set_addr = cur_mod;
          set_n    = dr_n_x[olr_pkg::CountW-1:0];
          set_nc   = dr_end_ext[olr_pkg::CursorW-1:0];
        end
      end
      olr_pkg::OP_STATUS: begin
        set_nc = head_ext[olr_pkg::CursorW-1:0];
      end
      default: begin
        set_n = '0;
      end
    endcase
  end

  assign stat_o.run_last = (run_left_q == olr_pkg::CountW'(1));

  // Store: written by appends, read one entry per issued result
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (ch_i != '0)) begin
      mem[head_q] <= ch_i;
    end
    if (cmd_i.issue) begin
      mem_rd_q <= mem[run_addr_q];
    end
  end

  // Pointers and marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      evicted_q <= 1'b0;
      wrapped_q <= 1'b0;
    end else if (cmd_i.append && (ch_i != '0)) begin
      head_q <= head_nxt;
      if (head_nxt == tail_q) begin
        tail_q    <= tail_q + AW'(1);
        evicted_q <= 1'b1;
      end
      if (head_q == LastIdx) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // Request latch and run counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_req) begin
      req_op_q  <= olr_pkg::op_e'(op_i);
      req_ml_q  <= max_len_i;
      req_cur_q <= cursor_i;
    end
    if (cmd_i.load_run) begin
      run_addr_q <= set_addr;
      run_cnt_q  <= set_n;
      run_real_q <= (set_n != '0);
      run_nc_q   <= set_nc;
    end else if (cmd_i.issue) begin
      run_addr_q <= run_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_left_q <= '0;
    end else if (cmd_i.load_run) begin
      run_left_q <= (set_n == '0) ? olr_pkg::CountW'(1) : set_n;
    end else if (cmd_i.issue) begin
      run_left_q <= run_left_q - olr_pkg::CountW'(1);
    end
  end

  // Result register, aligned with the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      out_bv_q   <= run_real_q;
      out_last_q <= stat_o.run_last;
      out_cnt_q  <= run_cnt_q;
      out_nc_q   <= run_nc_q;
      out_fill_q <= fill12;
      out_ovf_q  <= evicted_q;
      // never-written entries read as zero
      out_wr_q   <= wrapped_q || (run_addr_q < head_q);
    end
  end

  assign strobe_o      = strobe_q;
  assign byte_out_o    = (out_bv_q && out_wr_q) ? mem_rd_q : '0;
  assign byte_valid_o  = out_bv_q;
  assign last_o        = out_last_q;
  assign count_o       = out_cnt_q;
  assign next_cursor_o = out_nc_q;
  assign fill_level_o  = out_fill_q;
  assign overflowed_o  = out_ovf_q;

  a_empty_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !out_bv_q |-> out_last_q)
    else $error("empty or status result not marked last");

  a_data_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && out_bv_q |-> (out_cnt_q != '0))
    else $error("data result with zero count");

  a_issue_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (run_left_q != '0))
    else $error("issue with no entries left in run");

  a_evict_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(evicted_q) |-> (fill_a == LastIdx))
    else $error("overflow mark set while ring not full");

endmodule

`default_nettype wire

// File: rtl/overwriting_log_ring.sv
// Overwriting log ring: appends are taken with busy_o low, leave it low and give no result.
// Read, drain and status requests hold busy_o high while the run is sized (SETUP) and while
// the store is read once per result (RUN), with n bytes returned and at least one result per
// request; the next item is taken once busy_o is low again. Results strobe out one per cycle,
// registered behind the store read, limited by the single store read port.
// Reset clears the pointers and overflow mark; entries never written read as zero.
// The receiver cannot stall; strobe_o marks each result for exactly one cycle.
`default_nettype none

module overwriting_log_ring #(
  parameter int unsigned RING_DEPTH  = olr_pkg::RingDepthDef,
  parameter int unsigned MAX_REQUEST = olr_pkg::MaxRequestDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [olr_pkg::OpW-1:0]         op_i,
  input  wire logic [olr_pkg::ByteW-1:0]       ch_i,
  input  wire logic [olr_pkg::LenW-1:0]        max_len_i,
  input  wire logic [olr_pkg::CursorW-1:0]     cursor_i,
  output logic                                 strobe_o,
  output logic [olr_pkg::ByteW-1:0]            byte_out_o,
  output logic                                 byte_valid_o,
  output logic                                 last_o,
  output logic [olr_pkg::CountW-1:0]           count_o,
  output logic [olr_pkg::CursorW-1:0]          next_cursor_o,
  output logic [olr_pkg::FillW-1:0]            fill_level_o,
  output logic                                 overflowed_o
);

  olr_pkg::cmd_t  cmd;
  olr_pkg::stat_t stat;

  olr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  olr_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .ch_i          (ch_i),
    .max_len_i     (max_len_i),
    .cursor_i      (cursor_i),
    .strobe_o      (strobe_o),
    .byte_out_o    (byte_out_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .count_o       (count_o),
    .next_cursor_o (next_cursor_o),
    .fill_level_o  (fill_level_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

`default_nettype wire
